>>> src/emr_pkg.sv
// ---------------------------------------------------------------------------
// emr_pkg: shared types and codes for the extent map range lookup
// Item and result layouts, queue command, table entry and kind codes.
// ---------------------------------------------------------------------------
package emr_pkg;

    localparam logic ITEM_WRITE  = 1'b0;
    localparam logic ITEM_LOOKUP = 1'b1;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_EMPTY  = 2'd2;
    localparam logic [1:0] CMD_WRAP   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_WRAP     = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [1:0] EKIND_ZERO = 2'd0;
    localparam logic [1:0] EKIND_MEM  = 2'd1;
    localparam logic [1:0] EKIND_DISC = 2'd2;
    localparam logic [1:0] EKIND_SD   = 2'd3;

    localparam logic [2:0] RKIND_PASS = 3'd4;

    localparam logic CFG_ENTRIES   = 1'b0;
    localparam logic CFG_RUN_LIMIT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  entry_index;
        logic [63:0] entry_start;
        logic [63:0] entry_length;
        logic [1:0]  entry_kind;
        logic [63:0] entry_source;
        logic [8:0]  entry_skip;
        logic [63:0] query_offset;
        logic [63:0] query_length;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        has_run;
        logic [63:0] run_start;
        logic [63:0] run_length;
        logic [2:0]  run_kind;
        logic [63:0] run_source;
        logic [8:0]  run_skip;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] length;
        logic [63:0] source;
        logic [1:0]  kind;
        logic [8:0]  skip;
    } entry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  index;
        entry_t      entry;
        logic [63:0] offset;
        logic [63:0] range_end;
    } cmd_t;

endpackage

>>> src/emr_item_if.sv
// ---------------------------------------------------------------------------
// emr_item_if: input item channel
// Valid/ready channel carrying one write or lookup item.
// ---------------------------------------------------------------------------
interface emr_item_if;
    import emr_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/emr_result_if.sv
// ---------------------------------------------------------------------------
// emr_result_if: result channel
// Valid/ready channel carrying one run or status result.
// ---------------------------------------------------------------------------
interface emr_result_if;
    import emr_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/emr_ram.sv
// ---------------------------------------------------------------------------
// emr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module emr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> src/emr_front.sv
// ---------------------------------------------------------------------------
// emr_front: item intake and classification
// Classifies each item and holds it in a two-entry command queue.
// ---------------------------------------------------------------------------
module emr_front (
    input  logic          clk,
    input  logic          rst_n,
    emr_item_if.sink      item,
    output logic          cmd_valid,
    output emr_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import emr_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    cmd_t        new_cmd;
    logic [64:0] sum;
    logic        push;

    // classify: the end is formed here so the back end sees it ready
    always_comb
    begin
        sum                 = {1'b0, item.payload.query_offset}
                              + {1'b0, item.payload.query_length};
        new_cmd.index        = item.payload.entry_index;
        new_cmd.entry.start  = item.payload.entry_start;
        new_cmd.entry.length = item.payload.entry_length;
        new_cmd.entry.source = item.payload.entry_source;
        new_cmd.entry.kind   = item.payload.entry_kind;
        new_cmd.entry.skip   = item.payload.entry_skip;
        new_cmd.offset       = item.payload.query_offset;
        new_cmd.range_end    = sum[63:0];
        if (item.payload.kind == ITEM_WRITE)
        begin
            new_cmd.op = CMD_WRITE;
        end
        else if (item.payload.query_length == 64'd0)
        begin
            new_cmd.op = CMD_EMPTY;
        end
        else if (sum[64])
        begin
            new_cmd.op = CMD_WRAP;
        end
        else
        begin
            new_cmd.op = CMD_LOOKUP;
        end
    end

    assign item.ready = (fill_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign cmd_valid  = (fill_reg != 2'd0);
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end
endmodule

>>> src/emr_back.sv
// ---------------------------------------------------------------------------
// emr_back: table store, search and run walk
// Writes table entries, binary-searches and walks extents into runs.
// ---------------------------------------------------------------------------
module emr_back #(
    parameter int MAX_EXTENTS = 256,
    parameter int SECTOR_SIZE = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  emr_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic [8:0]       entries_in_use,
    input  logic [5:0]       run_limit,
    emr_result_if.source     result
);
    import emr_pkg::*;

    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int SB = $clog2(SECTOR_SIZE);
    localparam int EW = $bits(entry_t);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SRCH_RD  = 3'd1;
    localparam logic [2:0] ST_SRCH_CMP = 3'd2;
    localparam logic [2:0] ST_WALK_TOP = 3'd3;
    localparam logic [2:0] ST_WALK_EVL = 3'd4;
    localparam logic [2:0] ST_WALK_FRM = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [6:0]    n_reg, n_next;
    logic [63:0]   offset_reg, offset_next, end_reg, end_next;
    logic [63:0]   cursor_reg, cursor_next;
    logic          inr_reg, inr_next;
    logic          hit_reg, hit_next, gap_cut_reg, gap_cut_next;
    logic [63:0]   e_start_reg, e_start_next, e_end_reg, e_end_next;
    logic [63:0]   delta_reg, delta_next, e_src_reg, e_src_next;
    logic [1:0]    e_kind_reg, e_kind_next;
    logic [8:0]    e_skip_reg, e_skip_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic [CW-1:0] count;
    logic [CW-1:0] mid_calc;
    logic          out_free;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_rdata;
    entry_t        rd_entry;
    logic [64:0]   end_sum;
    logic [63:0]   sat_end;
    logic [63:0]   run_end;
    logic [SB:0]   b_sum;
    logic          b_carry;
    logic [SB:0]   b_rem;

    emr_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (cmd.entry),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign count    = (32'(entries_in_use) > MAX_EXTENTS) ? CW'(MAX_EXTENTS)
                                                           : CW'(entries_in_use);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_free = !out_valid_reg || result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // saturating end of the entry just read
    assign end_sum = {1'b0, rd_entry.start} + {1'b0, rd_entry.length};
    assign sat_end = end_sum[64] ? {64{1'b1}} : end_sum[63:0];

    // sd split: in-sector remainder plus skip stays below twice the sector
    assign b_sum   = {1'b0, delta_reg[SB-1:0]} + (SB+1)'(e_skip_reg);
    assign b_carry = (b_sum >= (SB+1)'(SECTOR_SIZE));
    assign b_rem   = b_carry ? b_sum - (SB+1)'(SECTOR_SIZE) : b_sum;

    always_comb
    begin
        if (hit_reg)
        begin
            run_end = (e_end_reg < end_reg) ? e_end_reg : end_reg;
            if (run_end < cursor_reg)
            begin
                run_end = cursor_reg;
            end
        end
        else
        begin
            run_end = gap_cut_reg ? e_start_reg : end_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        offset_next    = offset_reg;
        end_next       = end_reg;
        cursor_next    = cursor_reg;
        inr_next       = inr_reg;
        hit_next       = hit_reg;
        gap_cut_next   = gap_cut_reg;
        e_start_next   = e_start_reg;
        e_end_next     = e_end_reg;
        delta_next     = delta_reg;
        e_src_next     = e_src_reg;
        e_kind_next    = e_kind_reg;
        e_skip_next    = e_skip_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = AW'(cmd.index);
        ram_re         = 1'b0;
        ram_raddr      = AW'(mid_calc);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_WRITE:
                        begin
                            cmd_pop = 1'b1;
                            ram_we  = (32'(cmd.index) < MAX_EXTENTS);
                        end
                        CMD_LOOKUP:
                        begin
                            cmd_pop     = 1'b1;
                            offset_next = cmd.offset;
                            end_next    = cmd.range_end;
                            cursor_next = cmd.offset;
                            lo_next     = '0;
                            hi_next     = count;
                            n_next      = 7'd0;
                            state_next  = ST_SRCH_RD;
                        end
                        default:
                        begin
                            // empty or wrapping range: one status-only result
                            if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                out_valid_next = 1'b1;
                                out_next       = '0;
                                out_next.status = (cmd.op == CMD_WRAP) ? STATUS_WRAP
                                                                      : STATUS_OK;
                                out_next.last  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    mid_next   = mid_calc;
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    idx_next   = lo_reg;
                    state_next = ST_WALK_TOP;
                end
            end
            ST_SRCH_CMP:
            begin
                if (sat_end <= offset_reg)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH_RD;
            end
            ST_WALK_TOP:
            begin
                if (n_reg >= 7'(run_limit))
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = '0;
                        out_next.status = STATUS_OVERFLOW;
                        out_next.last   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    ram_re     = (idx_reg < count);
                    ram_raddr  = AW'(idx_reg);
                    inr_next   = (idx_reg < count);
                    state_next = ST_WALK_EVL;
                end
            end
            ST_WALK_EVL:
            begin
                hit_next     = inr_reg && (rd_entry.start <= cursor_reg);
                gap_cut_next = inr_reg && (rd_entry.start < end_reg);
                e_start_next = rd_entry.start;
                e_end_next   = sat_end;
                delta_next   = cursor_reg - rd_entry.start;
                e_src_next   = rd_entry.source;
                e_kind_next  = rd_entry.kind;
                e_skip_next  = rd_entry.skip;
                state_next   = ST_WALK_FRM;
            end
            ST_WALK_FRM:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next            = '0;
                    out_next.status     = STATUS_OK;
                    out_next.has_run    = 1'b1;
                    out_next.run_start  = cursor_reg;
                    out_next.run_length = run_end - cursor_reg;
                    out_next.last       = (run_end == end_reg);
                    if (hit_reg)
                    begin
                        out_next.run_kind = {1'b0, e_kind_reg};
                        case (e_kind_reg)
                            EKIND_MEM, EKIND_DISC:
                            begin
                                out_next.run_source = e_src_reg + delta_reg;
                            end
                            EKIND_SD:
                            begin
                                out_next.run_source = e_src_reg + (delta_reg >> SB)
                                                      + 64'(b_carry);
                                out_next.run_skip   = 9'(b_rem);
                            end
                            default:
                            begin
                                out_next.run_source = 64'd0;
                            end
                        endcase
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        out_next.run_kind = RKIND_PASS;
                    end
                    cursor_next = run_end;
                    n_next      = n_reg + 7'd1;
                    state_next  = (run_end == end_reg) ? ST_IDLE : ST_WALK_TOP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        offset_reg  <= offset_next;
        end_reg     <= end_next;
        cursor_reg  <= cursor_next;
        inr_reg     <= inr_next;
        hit_reg     <= hit_next;
        gap_cut_reg <= gap_cut_next;
        e_start_reg <= e_start_next;
        e_end_reg   <= e_end_next;
        delta_reg   <= delta_next;
        e_src_reg   <= e_src_next;
        e_kind_reg  <= e_kind_next;
        e_skip_reg  <= e_skip_next;
        out_reg     <= out_next;
    end
endmodule

>>> src/extent_map_range_lookup_core.sv
// ---------------------------------------------------------------------------
// extent_map_range_lookup_core: extent map range translation
// Stores sorted extents and translates a virtual range into runs.
// ---------------------------------------------------------------------------
//   channel  dir  payload   transfer when
//   item     in   item_t    item.valid && item.ready
//   result   out  result_t  result.valid && result.ready
//   cfg      in   9 bits    cfg_we (no ready)
//
// Steps: a write is stored in the back end straight from idle. A lookup
// binary-searches the table, a read state and a compare state per probe (one
// RAM read port), and then walks each run through read, evaluate and form
// states. Empty and wrapping ranges give a single status-only result.
// Reset clears control and config registers only; the table needs no clearing pass.
// A two-entry command queue lets intake continue while a result stalls.
// SECTOR_SIZE must be a power of two.
// ---------------------------------------------------------------------------
module extent_map_range_lookup_core #(
    parameter int MAX_EXTENTS = 256,
    parameter int SECTOR_SIZE = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    emr_item_if.sink     item,
    emr_result_if.source result,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [8:0]   cfg_data
);
    import emr_pkg::*;

    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    logic [8:0] entries_reg;
    logic [5:0] run_limit_reg;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= 9'd0;
            run_limit_reg <= 6'd63;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRIES:   entries_reg   <= cfg_data;
                CFG_RUN_LIMIT: run_limit_reg <= cfg_data[5:0];
                default:       entries_reg   <= entries_reg;
            endcase
        end
    end

    // front: accept and classify, queue commands
    emr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: table writes, search, run walk and result register
    emr_back #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .SECTOR_SIZE (SECTOR_SIZE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .entries_in_use (entries_reg),
        .run_limit      (run_limit_reg),
        .result         (result)
    );
endmodule
